// ----- src/ntm_pkg.sv -----
// Shared types and codes of the neighbor table manager.
package ntm_pkg;

   localparam int TABLE_ENTRIES_DEF = 2048;
   localparam int PENDING_MAX_DEF = 15;
   localparam int PEND_W = 8;

   localparam logic [2:0] ACT_GET = 3'd0;
   localparam logic [2:0] ACT_RESOLVED = 3'd1;
   localparam logic [2:0] ACT_DELETED = 3'd2;
   localparam logic [2:0] ACT_SEND = 3'd3;
   localparam logic [2:0] ACT_RELEASE = 3'd4;

   localparam logic [2:0] ENT_UNUSED = 3'd0;
   localparam logic [2:0] ENT_RESOLVING = 3'd1;
   localparam logic [2:0] ENT_VALID = 3'd2;
   localparam logic [2:0] ENT_STALE = 3'd3;
   localparam logic [2:0] ENT_FAILED = 3'd4;

   localparam logic [3:0] RES_HIT = 4'd0;
   localparam logic [3:0] RES_NEW = 4'd1;
   localparam logic [3:0] RES_FULL = 4'd2;
   localparam logic [3:0] RES_NO_MATCH = 4'd3;
   localparam logic [3:0] RES_SENT = 4'd4;
   localparam logic [3:0] RES_QUEUED = 4'd5;
   localparam logic [3:0] RES_UNREACH = 4'd6;
   localparam logic [3:0] RES_QUEUE_FULL = 4'd7;
   localparam logic [3:0] RES_BAD_ENTRY = 4'd8;

   localparam logic [15:0] VLAN_ID_UNSET = 16'h0fff;
   localparam logic [15:0] REFS_MAX = 16'hffff;

   typedef struct packed {
      logic [2:0]        state;
      logic [31:0]       addr;
      logic [15:0]       ifindex;
      logic [1:0]        port;
      logic [15:0]       refs;
      logic [47:0]       mac;
      logic [15:0]       vlan;
      logic [PEND_W-1:0] pending;
   } entry_type;

endpackage

// ----- src/ntm_table.sv -----
// Entry memory: one write port, one registered read port.
module ntm_table
   import ntm_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   localparam int IW = $clog2(TABLE_ENTRIES)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/neighbor_table_manager.sv -----
// Neighbor table manager: sequencer that scans the entry memory one entry per cycle.
// Get: match scan, then free-entry search in two passes; updates: match scan only;
// send and release: one entry read and an access step; bad codes answer directly from idle.
// The memory read port sets the pace: one entry is compared per cycle.
// After reset a clearing pass over all TABLE_ENTRIES entries keeps busy high.
// One result per request, strobed for one cycle on rsp_valid; the receiver cannot stall.
module neighbor_table_manager
   import ntm_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int PENDING_MAX = PENDING_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_ip_addr,
   input  logic [15:0] req_ifnum,
   input  logic [1:0]  req_port,
   input  logic [47:0] req_mac,
   input  logic [15:0] req_vlan_tag,
   input  logic [10:0] req_entry_index,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [10:0] rsp_result_index,
   output logic        rsp_resolve_request,
   output logic        rsp_write_valid,
   output logic [1:0]  rsp_write_port,
   output logic [11:0] rsp_write_vlan_id,
   output logic [2:0]  rsp_write_prio,
   output logic [47:0] rsp_write_mac,
   output logic [3:0]  rsp_released_count,
   output logic [3:0]  rsp_dropped_count
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FIND, S_CLAIM1, S_CLAIM2, S_ACCESS
   } fsm_type;

   fsm_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] tag_ff, tag_in;
   logic [IW-1:0] free_ff, free_in;
   logic [CW-1:0] sstart_ff, sstart_in;

   logic [2:0]  act_ff;
   logic [31:0] ip_ff;
   logic [15:0] ifx_ff;
   logic [1:0]  port_ff;
   logic [47:0] mac_ff;
   logic [15:0] vtag_ff;

   logic        rsp_valid_ff;
   logic [3:0]  status_ff, r_status;
   logic [10:0] index_ff, r_index;
   logic        resolve_ff, r_resolve;
   logic        wv_ff, r_wv;
   logic [1:0]  wport_ff, r_wport;
   logic [11:0] vid_ff, r_vid;
   logic [2:0]  prio_ff, r_prio;
   logic [47:0] wmac_ff, r_wmac;
   logic [3:0]  rel_ff, r_rel;
   logic [3:0]  drop_ff, r_drop;
   logic        finish;

   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   entry_type     rd_data, wr_data;

   logic accept, issue, hit, in_range;

   ntm_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign issue = (cnt_ff < CW'(TABLE_ENTRIES));
   assign in_range = (32'(req_entry_index) < 32'(TABLE_ENTRIES));

   always_comb begin
      if (state_ff == S_FIND) begin
         hit = (rd_data.state != ENT_UNUSED) && (rd_data.addr == ip_ff) &&
               (rd_data.ifindex == ifx_ff) &&
               ((act_ff != ACT_GET) || (rd_data.port == port_ff));
      end else begin
         hit = (rd_data.refs == 16'd0);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      tag_in = tag_ff;
      free_in = free_ff;
      sstart_in = sstart_ff;
      rd_en = 1'b0;
      rd_addr = cnt_ff[IW-1:0];
      wr_en = 1'b0;
      wr_addr = tag_ff;
      wr_data = rd_data;
      finish = 1'b0;
      r_status = RES_BAD_ENTRY;
      r_index = '0;
      r_resolve = 1'b0;
      r_wv = 1'b0;
      r_wport = '0;
      r_vid = '0;
      r_prio = '0;
      r_wmac = '0;
      r_rel = '0;
      r_drop = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = cnt_ff[IW-1:0];
            wr_data = '0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               pend_in = 1'b0;
               case (req_action)
                  ACT_GET, ACT_RESOLVED, ACT_DELETED: begin
                     state_in = S_FIND;
                  end
                  ACT_SEND, ACT_RELEASE: begin
                     if (in_range) begin
                        rd_en = 1'b1;
                        rd_addr = IW'(req_entry_index);
                        tag_in = IW'(req_entry_index);
                        state_in = S_ACCESS;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_FIND, S_CLAIM1, S_CLAIM2: begin
            if (pend_ff && hit) begin
               wr_en = 1'b1;
               finish = 1'b1;
               r_index = 11'(tag_ff);
               r_status = RES_HIT;
               if (state_ff != S_FIND) begin
                  // claim the free entry
                  sstart_in = CW'(tag_ff) + 1'b1;
                  free_in = free_ff - 1'b1;
                  wr_data.state = ENT_RESOLVING;
                  wr_data.addr = ip_ff;
                  wr_data.ifindex = ifx_ff;
                  wr_data.port = port_ff;
                  wr_data.refs = 16'd1;
                  wr_data.vlan = VLAN_ID_UNSET;
                  r_status = RES_NEW;
               end else if (act_ff == ACT_GET) begin
                  if (rd_data.refs == 16'd0 && free_ff != '0) begin
                     free_in = free_ff - 1'b1;
                  end
                  if (rd_data.refs != REFS_MAX) begin
                     wr_data.refs = rd_data.refs + 16'd1;
                  end
               end else if (act_ff == ACT_DELETED) begin
                  if (rd_data.state == ENT_RESOLVING || rd_data.state == ENT_FAILED) begin
                     wr_data.state = ENT_FAILED;
                     r_drop = rd_data.pending[3:0];
                     wr_data.pending = '0;
                  end else begin
                     wr_data.state = ENT_STALE;
                  end
               end else begin
                  if (rd_data.state == ENT_RESOLVING || rd_data.state == ENT_FAILED ||
                      rd_data.mac != mac_ff) begin
                     wr_data.mac = mac_ff;
                     wr_data.vlan = vtag_ff;
                     r_wv = 1'b1;
                     r_wport = rd_data.port;
                     r_vid = vtag_ff[11:0];
                     r_prio = vtag_ff[15:13];
                     r_wmac = mac_ff;
                     r_rel = rd_data.pending[3:0];
                     wr_data.pending = '0;
                  end
                  wr_data.state = ENT_VALID;
               end
            end else if (issue) begin
               rd_en = 1'b1;
               tag_in = cnt_ff[IW-1:0];
               cnt_in = cnt_ff + 1'b1;
               pend_in = 1'b1;
            end else if (pend_ff) begin
               // drain the last read before declaring a miss
               pend_in = 1'b0;
            end else begin
               pend_in = 1'b0;
               case (state_ff)
                  S_FIND: begin
                     if (act_ff != ACT_GET) begin
                        finish = 1'b1;
                        r_status = RES_NO_MATCH;
                     end else if (free_ff == '0) begin
                        finish = 1'b1;
                        r_status = RES_FULL;
                     end else begin
                        state_in = S_CLAIM1;
                        cnt_in = sstart_ff;
                     end
                  end
                  S_CLAIM1: begin
                     state_in = S_CLAIM2;
                     cnt_in = CW'(1);
                  end
                  default: begin
                     finish = 1'b1;
                     r_status = RES_FULL;
                  end
               endcase
            end
         end
         S_ACCESS: begin
            finish = 1'b1;
            if (act_ff == ACT_SEND) begin
               case (rd_data.state)
                  ENT_UNUSED: begin
                     r_status = RES_BAD_ENTRY;
                  end
                  ENT_STALE: begin
                     r_status = RES_SENT;
                     r_index = 11'(tag_ff);
                     r_resolve = 1'b1;
                  end
                  ENT_VALID: begin
                     r_status = RES_SENT;
                     r_index = 11'(tag_ff);
                  end
                  ENT_RESOLVING: begin
                     r_index = 11'(tag_ff);
                     if (rd_data.pending >= PEND_W'(PENDING_MAX)) begin
                        r_status = RES_QUEUE_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_data.pending = rd_data.pending + 1'b1;
                        r_status = RES_QUEUED;
                        r_resolve = 1'b1;
                     end
                  end
                  default: begin
                     r_status = RES_UNREACH;
                     r_index = 11'(tag_ff);
                  end
               endcase
            end else if (rd_data.refs != 16'd0) begin
               wr_en = 1'b1;
               wr_data.refs = rd_data.refs - 16'd1;
               if (rd_data.refs == 16'd1 && free_ff < IW'(TABLE_ENTRIES - 1)) begin
                  free_in = free_ff + 1'b1;
               end
               r_status = RES_HIT;
               r_index = 11'(tag_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         free_ff <= IW'(TABLE_ENTRIES - 1);
         sstart_ff <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         free_ff <= free_in;
         sstart_ff <= sstart_in;
         rsp_valid_ff <= finish;
      end
      tag_ff <= tag_in;
      if (accept) begin
         act_ff <= req_action;
         ip_ff <= req_ip_addr;
         ifx_ff <= req_ifnum;
         port_ff <= req_port;
         mac_ff <= req_mac;
         vtag_ff <= req_vlan_tag;
      end
      if (finish) begin
         status_ff <= r_status;
         index_ff <= r_index;
         resolve_ff <= r_resolve;
         wv_ff <= r_wv;
         wport_ff <= r_wport;
         vid_ff <= r_vid;
         prio_ff <= r_prio;
         wmac_ff <= r_wmac;
         rel_ff <= r_rel;
         drop_ff <= r_drop;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_result_index = index_ff;
   assign rsp_resolve_request = resolve_ff;
   assign rsp_write_valid = wv_ff;
   assign rsp_write_port = wport_ff;
   assign rsp_write_vlan_id = vid_ff;
   assign rsp_write_prio = prio_ff;
   assign rsp_write_mac = wmac_ff;
   assign rsp_released_count = rel_ff;
   assign rsp_dropped_count = drop_ff;

endmodule
